>>> rtl/core/wto_pkg.sv
// Shared constants and types of the wavetable oscillator.
`timescale 1ns / 1ps
package wto_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_BITS = 16;

	// Field and register widths.
	localparam int INC_W  = 27;
	localparam int SIZE_W = 11;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 16;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 27;
	localparam int CFG_IDX_W = 1;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	// Derived widths.
	localparam int ADDR_W     = $clog2(TABLE_DEPTH);
	localparam int PHASE_W    = ADDR_W + FRAC_BITS;
	localparam int SIZE_USE_W = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W      = ((PHASE_W + 1 > INC_W) ? PHASE_W + 1 : INC_W) + 1;
	localparam int INT_W      = SUM_W - FRAC_BITS;
	localparam int CNT_W      = $clog2(INT_W);

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b1;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic [IDX_W-1:0]         index;
		logic signed [VAL_W-1:0]  value;
	} op_t;

endpackage

>>> rtl/core/wto_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/wto_front.sv
// Front end: accepts input beats, decodes them and queues them in order.
`timescale 1ns / 1ps
module wto_front
	import wto_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // [9:0] table_index, [25:10] table_value
	input  logic                s_axis_tuser,  // [0] action
	output op_t                 head,
	output logic                head_valid,
	input  logic                head_pop
);

	op_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	op_t               entry;
	logic              push;
	logic              pop;

	always_comb begin
		entry.kind  = s_axis_tuser ? OP_WRITE : OP_TICK;
		entry.index = s_axis_tdata[IDX_W-1:0];
		entry.value = s_axis_tdata[IDX_W +: VAL_W];
	end

	assign s_axis_tready = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid & s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign pop           = head_pop & head_valid;
	assign head          = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/wto_back.sv
// Back end: table writes, phase accumulator with wrap, table read and output buffer.
`timescale 1ns / 1ps
module wto_back
	import wto_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  op_t                      head,
	input  logic                     head_valid,
	output logic                     head_pop,
	input  logic signed [INC_W-1:0]  phase_inc,
	input  logic [SIZE_W-1:0]        table_size,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [M_DATA_W-1:0]      m_axis_tdata
);

	// Phase and remainder unit state
	logic [PHASE_W-1:0]    phase_q;
	logic                  busy_q;
	logic [INT_W-1:0]      rem_q;
	logic [INT_W-1:0]      dvd_q;
	logic                  neg_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [SIZE_USE_W-1:0] div_q;
	logic [CNT_W-1:0]      cnt_q;

	// Read pipeline and 2-entry output buffer
	logic                   rd_valid_s2;
	logic [SAMPLE_BITS-1:0] rd_data_s2;
	logic [SAMPLE_BITS-1:0] out_buf_q [2];
	logic                   out_wr_q;
	logic                   out_rd_q;
	logic [1:0]             out_cnt_q;

	logic [SIZE_USE_W-1:0]   size_use;
	logic signed [SUM_W-1:0] span;
	logic signed [SUM_W-1:0] sum0;
	logic signed [SUM_W-1:0] sum_lo;
	logic signed [SUM_W-1:0] sum_hi;
	logic signed [SUM_W-1:0] wrapped;
	logic                    in_range;
	logic [INT_W-1:0]        int_part;
	logic [INT_W-1:0]        int_mag;
	logic [INT_W-1:0]        trial;
	logic [INT_W-1:0]        rem_next;
	logic [INT_W-1:0]        fin_int;
	logic [2:0]              pending;
	logic                    out_pop;
	logic                    room;
	logic                    do_tick;
	logic                    do_write;

	// Clamp the size in use to [1, TABLE_DEPTH].
	always_comb begin
		priority if (table_size == '0) begin
			size_use = SIZE_USE_W'(1);
		end else if (SIZE_USE_W'(table_size) > SIZE_USE_W'(TABLE_DEPTH)) begin
			size_use = SIZE_USE_W'(TABLE_DEPTH);
		end else begin
			size_use = SIZE_USE_W'(table_size);
		end
	end

	assign span   = $signed(SUM_W'({size_use, {FRAC_BITS{1'b0}}}));
	assign sum0   = $signed(SUM_W'(phase_q)) + SUM_W'(phase_inc);
	assign sum_lo = sum0 - span;
	assign sum_hi = sum0 + span;

	// Single wrap; anything still out of range goes to the remainder unit.
	always_comb begin
		priority if (sum0 >= span) begin
			wrapped = sum_lo;
		end else if (sum0 < 0) begin
			wrapped = sum_hi;
		end else begin
			wrapped = sum0;
		end
	end

	assign in_range = (wrapped >= 0) && (wrapped < span);
	assign int_part = sum0[SUM_W-1:FRAC_BITS];
	assign int_mag  = sum0[SUM_W-1] ? (~int_part + 1'b1) : int_part;

	// One restoring-remainder step per cycle.
	assign trial    = {rem_q[INT_W-2:0], dvd_q[INT_W-1]};
	assign rem_next = (trial >= INT_W'(div_q)) ? (trial - INT_W'(div_q)) : trial;
	assign fin_int  = (neg_q && rem_next != '0) ? (INT_W'(div_q) - rem_next) : rem_next;

	// Issue a tick only if its sample has a guaranteed slot in the output buffer.
	assign out_pop  = m_axis_tvalid & m_axis_tready;
	assign pending  = 3'(out_cnt_q) + 3'(rd_valid_s2);
	assign room     = (pending < 3'd2) | out_pop;
	assign head_pop = head_valid & ~busy_q & ((head.kind == OP_WRITE) | room);
	assign do_tick  = head_pop & (head.kind == OP_TICK);
	assign do_write = head_pop & (head.kind == OP_WRITE)
	                  & ((IDX_W + 1)'(head.index) < (IDX_W + 1)'(TABLE_DEPTH));

	wto_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (do_write),
		.waddr (ADDR_W'(head.index)),
		.wdata (SAMPLE_BITS'(head.value)),
		.re    (do_tick),
		.raddr (phase_q[PHASE_W-1:FRAC_BITS]),
		.rdata (rd_data_s2)
	);

	assign m_axis_tvalid = (out_cnt_q != 2'd0);
	assign m_axis_tdata  = {OUT_W'(out_buf_q[out_rd_q]), OUT_W'(out_buf_q[out_rd_q])};

	always_ff @(posedge clk) begin
		if (rd_valid_s2) begin
			out_buf_q[out_wr_q] <= rd_data_s2;
		end
		if (do_tick && !in_range) begin
			neg_q  <= sum0[SUM_W-1];
			dvd_q  <= int_mag;
			frac_q <= sum0[FRAC_BITS-1:0];
			div_q  <= size_use;
			rem_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[INT_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			rd_valid_s2 <= 1'b0;
			out_wr_q    <= 1'b0;
			out_rd_q    <= 1'b0;
			out_cnt_q   <= 2'd0;
		end else begin
			rd_valid_s2 <= do_tick;
			if (do_tick) begin
				if (in_range) begin
					phase_q <= wrapped[PHASE_W-1:0];
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(INT_W - 1)) begin
					busy_q  <= 1'b0;
					phase_q <= {fin_int[ADDR_W-1:0], frac_q};
				end
			end
			if (rd_valid_s2) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			unique case ({rd_valid_s2, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/wavetable_oscillator_unit.sv
// Wavetable oscillator top level: configuration registers, front end and back end.
//
// Wavetable oscillator with a phase accumulator. An input beat with tuser = 1 writes one
// signed 16-bit sample into the 1024-entry wave table; a beat with tuser = 0 is a tick that
// emits one stereo frame (left = right = table entry at the integer part of the phase) and
// then advances the phase by the signed Q10.16 phase_increment register, wrapping against
// table_size entries (0 acts as 1, above 1024 acts as 1024). Beats are queued in order in a
// 4-deep command queue and executed at one per cycle while neither the remainder unit nor a
// full output buffer holds them; a tick's frame passes from the queue through the registered
// table read into a 2-entry output buffer, which lets new beats flow in while a frame waits
// for tready. A tick whose step leaves the phase more than one table span out of range (large
// increment, or table_size lowered below the phase) runs the wrap through a bit-serial remainder
// unit, during which the back end holds. Table entries hold nothing useful until written, and a
// tick must not read one never written since reset. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no beat is in flight; the block does not enforce this.
`timescale 1ns / 1ps
module wavetable_oscillator_unit
	import wto_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,     // 0 phase_increment, 1 table_size
	input  logic [CFG_W-1:0]     cfg_data,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_DATA_W-1:0]  s_axis_tdata,  // [9:0] table_index, [25:10] table_value
	input  logic                 s_axis_tuser,  // [0] action
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_DATA_W-1:0]  m_axis_tdata   // [15:0] left_sample, [31:16] right_sample
);

	logic signed [INC_W-1:0] phase_inc_q;
	logic [SIZE_W-1:0]       table_size_q;
	op_t                     head;
	logic                    head_valid;
	logic                    head_pop;

	// Config registers; reset to a unit step over the full table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q  <= INC_W'(65536);
			table_size_q <= SIZE_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_INC:  phase_inc_q  <= cfg_data[INC_W-1:0];
				REG_TABLE_SIZE: table_size_q <= cfg_data[SIZE_W-1:0];
				default:        ;
			endcase
		end
	end

	// Front: accept and decode beats into the command queue.
	wto_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head          (head),
		.head_valid    (head_valid),
		.head_pop      (head_pop)
	);

	// Back: table writes, phase update, sample read and output buffer.
	wto_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.head_pop      (head_pop),
		.phase_inc     (phase_inc_q),
		.table_size    (table_size_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> rtl/core/wto_checker.sv
// Port-level checks of the wavetable oscillator, bound to the top level.
`timescale 1ns / 1ps
module wto_checker
	import wto_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata
);

	// A stalled frame stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output frame dropped or changed while stalled");

	// Both channels carry the same sample.
	a_stereo_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:0] == m_axis_tdata[2*OUT_W-1:OUT_W])
		else $error("left and right samples differ");

	// Out of reset: no frame pending and input open.
	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid && s_axis_tready)
		else $error("block not empty after reset");

endmodule

bind wavetable_oscillator_unit wto_checker u_wto_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
